// ===== sv/arp_pkg.sv =====
// Shared types, codes and constants of the ARP mapping table with aging.
`default_nettype none

package arp_pkg;

  // Default table depth and fixed field widths
  localparam int TABLE_ENTRIES_DEFAULT = 32;
  localparam int IP_W                  = 32;
  localparam int MAC_W                 = 48;
  localparam int AGE_W                 = 8;
  localparam int LFSR_W                = 16;

  localparam logic [LFSR_W-1:0] LFSR_SEED     = 16'hACE1;
  localparam logic [AGE_W-1:0]  TIMEOUT_RESET = 8'd15;
  localparam logic [AGE_W-1:0]  AGE_MAX       = 8'hFF;

  // Operation codes of an input transaction
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_TICK   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_VICTIM,
    ST_DONE
  } state_e;

  // Input transaction payload
  typedef struct packed {
    logic [1:0]       operation;
    logic [IP_W-1:0]  ip_addr;
    logic [MAC_W-1:0] mac_addr;
  } in_t;

  // Result transaction payload
  typedef struct packed {
    logic             hit;
    logic [MAC_W-1:0] mac_out;
  } out_t;

  // Request broadcast to every cell
  typedef struct packed {
    op_e              op;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic [AGE_W-1:0] timeout;
  } req_t;

  // Data handed from one cell to the next along with the token
  typedef struct packed {
    logic             claimed;
    logic [MAC_W-1:0] mac;
  } carry_t;

endpackage

`default_nettype wire

// ===== sv/arp_mapping_table_with_aging_core.sv =====
// Top level of the ARP mapping table with aging: controller and chain of slot cells.
//
// Usage:
//   Input channel (in_valid, in_stall, in_data) carries one operation per
//   transaction: lookup, insert or one-second aging tick. Output channel
//   (out_valid, out_stall, out_data) returns exactly one result per input
//   transaction: hit and MAC for a lookup, zeros otherwise.
//   cfg_write_en / cfg_write_data write the entry timeout (reset 15); write it
//   only while no transaction is in flight.
//   Each transaction sends a token down a chain of TABLE_ENTRIES cells, one
//   cell a cycle; a new transaction is accepted only after the result of the
//   previous one has been loaded into the output register. An insert that
//   finds no free slot then writes the victim slot; the victim slot is
//   computed while the token runs down the chain, and the controller waits
//   for it if it is not yet ready.
//   Reset clears all valid bits and ages, loads the LFSR seed and the default
//   timeout; no clearing pass is needed.
//   While the receiver stalls, the result is held in the output register and a
//   new transaction may still be accepted; its result waits until the output
//   register frees.
`default_nettype none

module arp_mapping_table_with_aging_core #(
  parameter int TABLE_ENTRIES = arp_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write_en,
  input  wire logic [arp_pkg::AGE_W-1:0]  cfg_write_data,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire arp_pkg::in_t               in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output arp_pkg::out_t                   out_data
);

  localparam int IW = $clog2(TABLE_ENTRIES);

  arp_pkg::state_e             state;
  arp_pkg::state_e             state_next;
  arp_pkg::req_t               req;
  logic                        start;
  logic [arp_pkg::LFSR_W-1:0]  lfsr;
  logic [arp_pkg::LFSR_W-1:0]  lfsr_next;
  logic                        res_hit;
  logic [arp_pkg::MAC_W-1:0]   res_mac;

  logic                        accept;
  logic                        last_tok;
  arp_pkg::carry_t             last_carry;
  logic                        victim_write;
  logic                        load_out;
  logic                        mod_busy;
  logic [IW-1:0]               victim_slot;
  logic                        insert_accept;

  logic [TABLE_ENTRIES-1:0]    tok;
  arp_pkg::carry_t             carry [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]    victim_we;

  assign accept        = in_valid && !in_stall;
  assign insert_accept = accept && (in_data.operation == arp_pkg::OP_INSERT);
  assign last_tok      = tok[TABLE_ENTRIES-1];
  assign last_carry    = carry[TABLE_ENTRIES-1];

  // Step the Fibonacci LFSR: taps at bits 0, 2, 3, 5
  assign lfsr_next = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[arp_pkg::LFSR_W-1:1]};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      arp_pkg::ST_IDLE: begin
        if (in_valid) state_next = arp_pkg::ST_RUN;
      end
      arp_pkg::ST_RUN: begin
        if (last_tok) begin
          if ((req.op == arp_pkg::OP_INSERT) && !last_carry.claimed) begin
            state_next = arp_pkg::ST_VICTIM;
          end else begin
            state_next = arp_pkg::ST_DONE;
          end
        end
      end
      arp_pkg::ST_VICTIM: begin
        if (!mod_busy) state_next = arp_pkg::ST_DONE;
      end
      arp_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) state_next = arp_pkg::ST_IDLE;
      end
      default: state_next = arp_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    in_stall     = (state != arp_pkg::ST_IDLE);
    victim_write = (state == arp_pkg::ST_VICTIM) && !mod_busy;
    load_out     = (state == arp_pkg::ST_DONE) && (!out_valid || !out_stall);
  end

  // Control registers and request capture
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= arp_pkg::ST_IDLE;
      start       <= 1'b0;
      lfsr        <= arp_pkg::LFSR_SEED;
      req.timeout <= arp_pkg::TIMEOUT_RESET;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      start <= accept;
      if (accept) begin
        req.op  <= arp_pkg::op_e'(in_data.operation);
        req.ip  <= in_data.ip_addr;
        req.mac <= in_data.mac_addr;
      end
      if (insert_accept) begin
        lfsr <= lfsr_next;
      end
      if (cfg_write_en) begin
        req.timeout <= cfg_write_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture the result payload
  always_ff @(posedge clk) begin
    if ((state == arp_pkg::ST_RUN) && last_tok) begin
      res_hit <= (req.op == arp_pkg::OP_LOOKUP) && last_carry.claimed;
      res_mac <= ((req.op == arp_pkg::OP_LOOKUP) && last_carry.claimed) ?
                 last_carry.mac : '0;
    end
    if (load_out) begin
      out_data.hit     <= res_hit;
      out_data.mac_out <= res_mac;
    end
  end

  // Victim slot: advanced LFSR value modulo the depth
  arp_victim_mod #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_victim_mod (
    .clk   (clk),
    .rst   (rst),
    .start (insert_accept),
    .value (lfsr_next),
    .busy  (mod_busy),
    .slot  (victim_slot)
  );

  // Chain of slot cells
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    assign victim_we[i] = victim_write && (victim_slot == IW'(i));

    if (i == 0) begin : g_head
      arp_cell u_cell (
        .clk          (clk),
        .rst          (rst),
        .token_in     (start),
        .carry_in     ('0),
        .req          (req),
        .write_victim (victim_we[i]),
        .token_out    (tok[i]),
        .carry_out    (carry[i])
      );
    end else begin : g_body
      arp_cell u_cell (
        .clk          (clk),
        .rst          (rst),
        .token_in     (tok[i-1]),
        .carry_in     (carry[i-1]),
        .req          (req),
        .write_victim (victim_we[i]),
        .token_out    (tok[i]),
        .carry_out    (carry[i])
      );
    end
  end

endmodule

`default_nettype wire

// ===== sv/arp_cell.sv =====
// One table slot: holds an entry and serves the request token passing through it.
`default_nettype none

module arp_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            token_in,
  input  wire arp_pkg::carry_t carry_in,
  input  wire arp_pkg::req_t   req,
  input  wire logic            write_victim,
  output logic                 token_out,
  output arp_pkg::carry_t      carry_out
);

  logic                        valid;
  logic [arp_pkg::AGE_W-1:0]   age;
  logic [arp_pkg::IP_W-1:0]    ip;
  logic [arp_pkg::MAC_W-1:0]   mac;

  logic                        match;
  logic [arp_pkg::AGE_W-1:0]   age_inc;
  logic                        take;
  logic                        fill;
  logic                        age_step;
  logic                        write;
  arp_pkg::carry_t             carry_next;

  // Compare and saturating age step
  assign match   = valid && (ip == req.ip);
  assign age_inc = (age == arp_pkg::AGE_MAX) ? age : age + arp_pkg::AGE_W'(1);

  // Serve the token: first match wins a lookup, first free slot takes an insert, a tick steps every age
  always_comb begin
    take     = 1'b0;
    fill     = 1'b0;
    age_step = 1'b0;
    if (token_in) begin
      unique case (req.op)
        arp_pkg::OP_LOOKUP: take     = !carry_in.claimed && match;
        arp_pkg::OP_INSERT: fill     = !carry_in.claimed && !valid;
        arp_pkg::OP_TICK:   age_step = 1'b1;
        arp_pkg::OP_NOP:    ;
        default:            ;
      endcase
    end
  end

  always_comb begin
    carry_next = carry_in;
    if (take) begin
      carry_next.claimed = 1'b1;
      carry_next.mac     = mac;
    end
    if (fill) begin
      carry_next.claimed = 1'b1;
    end
  end

  assign write = fill || write_victim;

  // Advance the token and update valid and age
  always_ff @(posedge clk) begin
    if (rst) begin
      token_out <= 1'b0;
      carry_out <= '0;
      valid     <= 1'b0;
      age       <= '0;
    end else begin
      token_out <= token_in;
      carry_out <= carry_next;
      if (write) begin
        valid <= 1'b1;
        age   <= '0;
      end else if (age_step) begin
        age <= age_inc;
        if (age_inc > req.timeout) begin
          valid <= 1'b0;
        end
      end
    end
  end

  // Hold entry contents
  always_ff @(posedge clk) begin
    if (write) begin
      ip  <= req.ip;
      mac <= req.mac;
    end
  end

endmodule

`default_nettype wire

// ===== sv/arp_victim_mod.sv =====
// Remainder of the LFSR value by the table depth, by reciprocal multiplication in a quotient step and a remainder step.
`default_nettype none

module arp_victim_mod #(
  parameter int ENTRIES = arp_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [arp_pkg::LFSR_W-1:0]  value,
  output logic                             busy,
  output logic [$clog2(ENTRIES)-1:0]       slot
);

  localparam int IW    = $clog2(ENTRIES);
  localparam int VW    = arp_pkg::LFSR_W;
  localparam int SHIFT = VW + IW;
  localparam int RW    = VW + 2;
  localparam int PW    = VW + RW;
  // Rounded-up reciprocal of the depth: exact quotient for every VW-bit value
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES);
  localparam logic [RW-1:0] RECIP   = RW'(RECIP_FULL);
  localparam logic [VW-1:0] DIVISOR = VW'(ENTRIES);

  logic [VW-1:0] val;
  logic [VW-1:0] quo;
  logic          second;
  logic [PW-1:0] prod;
  logic [VW-1:0] quo_next;
  logic [VW-1:0] rem;

  // Quotient from the reciprocal, remainder from the quotient
  assign prod     = PW'(val) * PW'(RECIP);
  assign quo_next = VW'(prod >> SHIFT);
  assign rem      = val - quo * DIVISOR;

  // Busy after start until the quotient step and then the remainder step are done
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      second <= 1'b0;
    end else if (start) begin
      busy   <= 1'b1;
      second <= 1'b0;
    end else if (busy) begin
      busy   <= !second;
      second <= !second;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val <= value;
    end else if (busy) begin
      if (second) begin
        slot <= rem[IW-1:0];
      end else begin
        quo <= quo_next;
      end
    end
  end

endmodule

`default_nettype wire
